@@ rtl/rcm_pkg.sv @@
// shared constants for the regulator code to millivolts decoder
`default_nettype none

package rcm_pkg;

    // number of rails that decode; indexes at or above this are unknown
    localparam int RAIL_COUNT = 14;

    localparam int RAIL_IDX_W = 4;
    localparam int CODE_W     = 8;
    localparam int MV_W       = 12;

    // rails with a scale of their own; every other known rail is a 100 mV ldo
    localparam logic [RAIL_IDX_W-1:0] RAIL_DCDC1   = 4'd0;
    localparam logic [RAIL_IDX_W-1:0] RAIL_DCDC2   = 4'd1;
    localparam logic [RAIL_IDX_W-1:0] RAIL_DCDC3   = 4'd2;
    localparam logic [RAIL_IDX_W-1:0] RAIL_DCDC4   = 4'd3;
    localparam logic [RAIL_IDX_W-1:0] RAIL_DCDC5   = 4'd4;
    localparam logic [RAIL_IDX_W-1:0] RAIL_CPUSLDO = 4'd11;

    // largest decoded voltage
    localparam logic [MV_W-1:0] MV_MAX = 12'd3700;

endpackage

`default_nettype wire

@@ rtl/regulator_code_to_millivolts.sv @@
// regulator voltage code to millivolts decoder, top level
`default_nettype none

// usage
// - command channel: drive rail_index and raw_code with start high; a transfer
//   happens at each rising edge where start is high and busy is low
// - busy is tied low: the decoder never stalls, so a command can follow in
//   every cycle
// - result channel: done is high for exactly one cycle with millivolts and
//   code_valid; the receiver takes it at the edge that ends that cycle and
//   cannot hold it off
// - path: a transferred command is held in the command register, then its
//   result in the result register, from which done rises and the result is
//   taken; throughput one per cycle
// - the decode is a few compares on the masked code and one small constant
//   multiply-add, all between the command register and the result register
// - an unknown rail or a code outside the rail's scale gives code_valid 0
//   and millivolts 0
// - reset (rst_n low, asynchronous) clears the pipeline valid bits, so no
//   result is emitted for commands in flight at reset
// - results are never stalled: done follows each accepted command in order
module regulator_code_to_millivolts
    import rcm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [RAIL_IDX_W-1:0] rail_index,
    input  wire logic [CODE_W-1:0]     raw_code,
    output logic                       done,
    output logic [MV_W-1:0]            millivolts,
    output logic                       code_valid
);

    // command register stage
    logic                  cmd_vld_reg;
    logic [RAIL_IDX_W-1:0] rail_reg;
    logic [CODE_W-1:0]     code_reg;

    // result register stage
    logic                  done_reg;
    logic [MV_W-1:0]       mv_reg;
    logic                  ok_reg;

    logic [MV_W-1:0]       mv_next;
    logic                  ok_next;

    logic                  cmd_xfer;
    logic [4:0]            n5;
    logic [6:0]            n7;
    logic [6:0]            n7_off71;
    logic [6:0]            n7_off88;
    logic                  rail_known;

    assign busy     = 1'b0;
    assign cmd_xfer = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            cmd_vld_reg <= cmd_xfer;
            done_reg    <= cmd_vld_reg;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            rail_reg <= rail_index;
            code_reg <= raw_code;
        end
        if (cmd_vld_reg)
        begin
            mv_reg <= mv_next;
            ok_reg <= ok_next;
        end
    end

    assign n5       = code_reg[4:0];
    assign n7       = code_reg[6:0];
    assign n7_off71 = n7 - 7'd71;
    assign n7_off88 = n7 - 7'd88;

    // rails at or above the rail count have no scale
    assign rail_known = ({1'b0, rail_reg} < (RAIL_IDX_W + 1)'(RAIL_COUNT));

    // per rail piecewise scale
    always_comb
    begin
        mv_next = '0;
        ok_next = 1'b0;
        if (rail_known)
        begin
            unique case (rail_reg)
                RAIL_DCDC1:
                begin
                    if (n5 <= 5'd19)
                    begin
                        mv_next = 12'd1500 + 12'(n5) * 12'd100;
                        ok_next = 1'b1;
                    end
                end
                RAIL_DCDC2, RAIL_DCDC3:
                begin
                    priority if (n7 <= 7'd70)
                    begin
                        mv_next = 12'd500 + 12'(n7) * 12'd10;
                        ok_next = 1'b1;
                    end
                    else if (n7 <= 7'd87)
                    begin
                        mv_next = 12'd1220 + 12'(n7_off71) * 12'd20;
                        ok_next = 1'b1;
                    end
                    else if (rail_reg == RAIL_DCDC3 && n7 <= 7'd106)
                    begin
                        mv_next = 12'd1600 + 12'(n7_off88) * 12'd100;
                        ok_next = 1'b1;
                    end
                    else
                    begin
                        ok_next = 1'b0;
                    end
                end
                RAIL_DCDC4:
                begin
                    priority if (n7 <= 7'd70)
                    begin
                        mv_next = 12'd500 + 12'(n7) * 12'd10;
                        ok_next = 1'b1;
                    end
                    else if (n7 <= 7'd102)
                    begin
                        mv_next = 12'd1220 + 12'(n7_off71) * 12'd20;
                        ok_next = 1'b1;
                    end
                    else
                    begin
                        ok_next = 1'b0;
                    end
                end
                RAIL_DCDC5:
                begin
                    // code 25 is a lone 1.2 V point below the linear range
                    priority if (n5 == 5'd25)
                    begin
                        mv_next = 12'd1200;
                        ok_next = 1'b1;
                    end
                    else if (n5 <= 5'd23)
                    begin
                        mv_next = 12'd1400 + 12'(n5) * 12'd100;
                        ok_next = 1'b1;
                    end
                    else
                    begin
                        ok_next = 1'b0;
                    end
                end
                RAIL_CPUSLDO:
                begin
                    if (n5 <= 5'd19)
                    begin
                        mv_next = 12'd500 + 12'(n5) * 12'd50;
                        ok_next = 1'b1;
                    end
                end
                default:
                begin
                    // aldo, bldo, dldo and any other known rail
                    if (n5 <= 5'd30)
                    begin
                        mv_next = 12'd500 + 12'(n5) * 12'd100;
                        ok_next = 1'b1;
                    end
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign millivolts = mv_reg;
    assign code_valid = ok_reg;

`ifndef SYNTHESIS
    // each command transfer yields a result, after the command and result registers
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> ##1 done)
        else $error("result missing after command transfer");

    // no rising done without a command transfer behind it, through both registers
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(cmd_xfer, 2))
        else $error("result without command");

    // an invalid code reports zero millivolts
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !code_valid) |-> (millivolts == '0))
        else $error("invalid result with nonzero millivolts");

    // decoded voltage stays in range
    a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (millivolts <= MV_MAX))
        else $error("millivolts out of range");
`endif

endmodule

`default_nettype wire
